// ===== rtl/wildcard_byte_pattern_finder_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef WILDCARD_BYTE_PATTERN_FINDER_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_FINDER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define WBPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked at every clock edge outside reset.
`define WBPF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wbpf_pkg.sv =====
package wbpf_pkg;

  localparam int MAX_PATTERN    = 8;
  localparam int VARIABLE_COUNT = 16;
  localparam int HIST_DEPTH     = MAX_PATTERN - 1;
  localparam int LEN_W          = 4;
  localparam int POS_W          = 32;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 64;
  localparam int SEL_W          = 4;

  localparam logic [31:0] VARS0_RST = 32'hF3F2F1F0;
  localparam logic [31:0] VARS1_RST = 32'hF7F6F5F4;
  localparam logic [31:0] VARS2_RST = 32'hFBFAF9F8;
  localparam logic [31:0] VARS3_RST = 32'hFFFEFDFC;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 4'd0,
    REG_WILDCARD_MASK  = 4'd1,
    REG_VARIABLE_MASK  = 4'd2,
    REG_PATTERN_LENGTH = 4'd3,
    REG_VARIABLES_0    = 4'd4,
    REG_VARIABLES_1    = 4'd5,
    REG_VARIABLES_2    = 4'd6,
    REG_VARIABLES_3    = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [8*MAX_PATTERN-1:0]    pattern_bytes;
    logic [MAX_PATTERN-1:0]      wildcard_mask;
    logic [MAX_PATTERN-1:0]      variable_mask;
    logic [LEN_W-1:0]            pattern_length;
    logic [8*VARIABLE_COUNT-1:0] variables;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

// ===== rtl/wbpf_cfg.sv =====
module wbpf_cfg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  wr_en,
  input  logic [wbpf_pkg::CFG_IDX_W-1:0]        wr_index,
  input  logic [wbpf_pkg::CFG_DATA_W-1:0]       wr_data,
  output wbpf_pkg::cfg_t                        cfg
);

  logic [63:0] pattern_bytes_r;
  logic [7:0]  wildcard_mask_r;
  logic [7:0]  variable_mask_r;
  logic [3:0]  pattern_length_r;
  logic [31:0] vars0_r, vars1_r, vars2_r, vars3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r  <= '0;
      wildcard_mask_r  <= '0;
      variable_mask_r  <= '0;
      pattern_length_r <= '0;
      vars0_r          <= wbpf_pkg::VARS0_RST;
      vars1_r          <= wbpf_pkg::VARS1_RST;
      vars2_r          <= wbpf_pkg::VARS2_RST;
      vars3_r          <= wbpf_pkg::VARS3_RST;
    end else if (wr_en) begin
      case (wbpf_pkg::cfg_idx_t'(wr_index))
        wbpf_pkg::REG_PATTERN_BYTES:  pattern_bytes_r  <= wr_data;
        wbpf_pkg::REG_WILDCARD_MASK:  wildcard_mask_r  <= wr_data[7:0];
        wbpf_pkg::REG_VARIABLE_MASK:  variable_mask_r  <= wr_data[7:0];
        wbpf_pkg::REG_PATTERN_LENGTH: pattern_length_r <= wr_data[3:0];
        wbpf_pkg::REG_VARIABLES_0:    vars0_r          <= wr_data[31:0];
        wbpf_pkg::REG_VARIABLES_1:    vars1_r          <= wr_data[31:0];
        wbpf_pkg::REG_VARIABLES_2:    vars2_r          <= wr_data[31:0];
        wbpf_pkg::REG_VARIABLES_3:    vars3_r          <= wr_data[31:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  assign cfg.pattern_bytes  = pattern_bytes_r;
  assign cfg.wildcard_mask  = wildcard_mask_r;
  assign cfg.variable_mask  = variable_mask_r;
  assign cfg.pattern_length = pattern_length_r;
  assign cfg.variables      = {vars3_r, vars2_r, vars1_r, vars0_r};

endmodule

// ===== rtl/wbpf_match.sv =====
module wbpf_match (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wbpf_pkg::cfg_t        cfg,
  input  logic                  advance,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output wbpf_pkg::result_t     result
);

  logic [7:0]                    hist_r [wbpf_pkg::HIST_DEPTH];
  logic [wbpf_pkg::POS_W-1:0]    seen_r;
  logic [wbpf_pkg::POS_W-1:0]    seen_nxt;
  logic                          answered_r;
  logic                          answered_nxt;

  logic [wbpf_pkg::LEN_W-1:0]    len;
  logic [wbpf_pkg::LEN_W-1:0]    len_m1;
  logic [wbpf_pkg::MAX_PATTERN-1:0] elem_ok;
  logic                          window_full;
  logic                          hit;

  // Clamp length to the element count.
  assign len = (cfg.pattern_length > wbpf_pkg::LEN_W'(wbpf_pkg::MAX_PATTERN)) ?
               wbpf_pkg::LEN_W'(wbpf_pkg::MAX_PATTERN) : cfg.pattern_length;
  assign len_m1 = len - 1'b1;

  always_comb begin
    logic [wbpf_pkg::LEN_W-1:0] d;
    logic [7:0]                 wb;
    logic [7:0]                 pb;
    logic [7:0]                 vb;
    logic [wbpf_pkg::SEL_W-1:0] sel;
    for (int i = 0; i < wbpf_pkg::MAX_PATTERN; i++) begin
      d   = len - wbpf_pkg::LEN_W'(i) - wbpf_pkg::LEN_W'(2);
      wb  = (wbpf_pkg::LEN_W'(i) == len_m1) ? data_byte :
            hist_r[d[$clog2(wbpf_pkg::HIST_DEPTH)-1:0]];
      pb  = cfg.pattern_bytes[8*i +: 8];
      sel = pb[wbpf_pkg::SEL_W-1:0];
      vb  = cfg.variables[{sel, 3'b000} +: 8];
      if (wbpf_pkg::LEN_W'(i) >= len) begin
        elem_ok[i] = 1'b1;
      end else if (cfg.wildcard_mask[i]) begin
        elem_ok[i] = 1'b1;
      end else if (cfg.variable_mask[i]) begin
        elem_ok[i] = (wb == vb);
      end else begin
        elem_ok[i] = (wb == pb);
      end
    end
  end

  assign window_full = (seen_r >= wbpf_pkg::POS_W'(len_m1));
  assign hit = (len == '0) || (window_full && (&elem_ok));

  assign result.valid    = !answered_r && (hit || last_byte);
  assign result.found    = hit;
  assign result.position = (!hit || len == '0) ? '0 : seen_r - wbpf_pkg::POS_W'(len_m1);

  always_comb begin
    seen_nxt     = seen_r;
    answered_nxt = answered_r;
    if (last_byte) begin
      seen_nxt     = '0;
      answered_nxt = 1'b0;
    end else begin
      if (seen_r != '1) begin
        seen_nxt = seen_r + 1'b1;
      end
      if (!answered_r && hit) begin
        answered_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      answered_r <= 1'b0;
    end else if (advance) begin
      seen_r     <= seen_nxt;
      answered_r <= answered_nxt;
    end
  end

  // history shift, newest first
  always_ff @(posedge clk) begin
    if (advance) begin
      hist_r[0] <= data_byte;
      for (int j = 1; j < wbpf_pkg::HIST_DEPTH; j++) begin
        hist_r[j] <= hist_r[j-1];
      end
    end
  end

endmodule

// ===== rtl/wildcard_byte_pattern_finder.sv =====
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    in_data_byte[7:0], in_last_byte
// out_     output     out_valid / out_stall  out_found, out_position[31:0]
// cfg_     input      cfg_valid / cfg_ready  cfg_index[3:0], cfg_data[63:0]
//
// One byte per cycle sustained unless the input stalls: a byte enters the input
// register, is matched against the window while held there, and a hit or last byte
// puts its result in the output register, from which out_valid is driven.
// Synchronous active-low reset clears counters, flags and valids.
// Input stalls only while the output register holds an untaken result.
`include "wildcard_byte_pattern_finder_macros.svh"

module wildcard_byte_pattern_finder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic [wbpf_pkg::POS_W-1:0]         out_position,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wbpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wbpf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  wbpf_pkg::cfg_t    cfg;
  wbpf_pkg::result_t res;

  logic                        s1_valid_r;
  logic [7:0]                  s1_byte_r;
  logic                        s1_last_r;
  logic                        out_valid_r;
  logic                        out_found_r;
  logic [wbpf_pkg::POS_W-1:0]  out_position_r;

  logic out_free;
  logic s1_fire;
  logic in_accept;

  assign cfg_ready = 1'b1;

  wbpf_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  wbpf_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .advance   (s1_fire),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold payload until the transaction completes
  always_ff @(posedge clk) begin
    if (s1_fire && res.valid) begin
      out_found_r    <= res.found;
      out_position_r <= res.position;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

  `WBPF_ASSERT(a_rise_from_s1, $rose(out_valid_r) |-> $past(s1_valid_r), "result without item")
  `WBPF_ASSERT_IMPLY(a_notfound_pos, out_valid_r && !out_found_r, out_position_r == '0, "bad position")
  `WBPF_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid_r && out_stall, "stall without cause")

endmodule
